// ----- rtl/core/vdl_pkg.sv -----
// shared types and constants of the vertex diffuse lighting block
// no dependencies; imported by the sequencer, the dot/mac unit and the top level
package vdl_pkg;

  localparam int unsigned NumLights = 7;
  localparam int unsigned LightIdxW = 3;
  localparam int unsigned LightW    = 63;
  localparam int unsigned AmbW      = 27;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CompW     = 13;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned FracBits  = 22;
  localparam int unsigned ProdW     = 2 * CompW;
  localparam int unsigned DotW      = ProdW + 2;
  localparam int unsigned MagW      = DotW - 1;
  localparam int unsigned MacW      = ByteW + MagW;
  localparam int unsigned AccW      = 40;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 24;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegAmbient = 3'd7;

  // light word layout
  localparam int unsigned DirXLsb = 24;
  localparam int unsigned DirYLsb = 37;
  localparam int unsigned DirZLsb = 50;
  localparam int unsigned CountLsb = 24;

  typedef enum logic [2:0] {
    StIdle,
    StLight,
    StFlush,
    StClamp,
    StOut
  } state_e;

  // sequencer to dot/mac unit control
  typedef struct packed {
    logic init;
    logic issue;
    logic load_out;
  } ctl_t;

endpackage

// ----- rtl/core/vdl_seq.sv -----
// sequencer: walks the lights in use through the shared dot/mac unit
// depends on vdl_pkg
module vdl_seq import vdl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  logic [LightIdxW-1:0] count_i,
  output logic [LightIdxW-1:0] light_idx_o,
  output ctl_t                 ctl_o
);

  state_e               state_q, state_d;
  logic [LightIdxW-1:0] idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    ctl_o       = '0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.init = 1'b1;
          idx_d      = '0;
          state_d    = (count_i == '0) ? StFlush : StLight;
        end
      end
      StLight: begin
        ctl_o.issue = 1'b1;
        idx_d       = idx_q + 1'b1;
        if (idx_q == count_i - 1'b1) begin
          state_d = StFlush;
        end
      end
      StFlush: begin
        state_d = StClamp;
      end
      StClamp: begin
        ctl_o.load_out = 1'b1;
        state_d        = StOut;
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign light_idx_o = idx_q;

endmodule

// ----- rtl/core/vdl_dot_mac.sv -----
// shared dot-and-accumulate unit: one light per cycle, two stages
// stage one forms the normal dot light direction, stage two adds colour times dot
// depends on vdl_pkg
module vdl_dot_mac import vdl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctl_t                ctl_i,
  input  logic [CompW-1:0]    nx_i,
  input  logic [CompW-1:0]    ny_i,
  input  logic [CompW-1:0]    nz_i,
  input  logic [LightW-1:0]   light_i,
  input  logic [AmbW-1:0]     ambient_i,
  output logic [OutDataW-1:0] rgb_o
);

  logic signed [CompW-1:0] nx_q, ny_q, nz_q;
  logic signed [CompW-1:0] lx, ly, lz;
  logic signed [ProdW-1:0] px, py, pz;
  logic signed [DotW-1:0]  dot_d, dot_q;
  logic [3*ByteW-1:0]      col_q;
  logic                    vld_q;
  logic                    dot_pos;
  logic [MagW-1:0]         dot_mag;
  logic [MacW-1:0]         prod [3];
  logic [AccW-1:0]         acc_q [3];
  logic [OutDataW-1:0]     rgb_q;
  logic [OutDataW-1:0]     rgb_d;

  assign lx = light_i[DirXLsb +: CompW];
  assign ly = light_i[DirYLsb +: CompW];
  assign lz = light_i[DirZLsb +: CompW];
  assign px = lx * nx_q;
  assign py = ly * ny_q;
  assign pz = lz * nz_q;
  assign dot_d = DotW'(px) + DotW'(py) + DotW'(pz);

  // strictly positive dot only
  assign dot_pos = vld_q && !dot_q[DotW-1] && (dot_q != '0);
  assign dot_mag = dot_q[MagW-1:0];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = MacW'(col_q[ch*ByteW +: ByteW]) * MacW'(dot_mag);
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (acc_q[ch][AccW-1:FracBits] > (AccW - FracBits)'(8'hFF)) begin
        rgb_d[ch*ByteW +: ByteW] = 8'hFF;
      end else begin
        rgb_d[ch*ByteW +: ByteW] = acc_q[ch][FracBits +: ByteW];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= ctl_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.init) begin
      nx_q <= nx_i;
      ny_q <= ny_i;
      nz_q <= nz_i;
    end
    dot_q <= dot_d;
    col_q <= light_i[3*ByteW-1:0];
    for (int ch = 0; ch < 3; ch++) begin
      if (ctl_i.init) begin
        acc_q[ch] <= AccW'(ambient_i[ch*ByteW +: ByteW]) << FracBits;
      end else if (dot_pos) begin
        acc_q[ch] <= acc_q[ch] + AccW'(prod[ch]);
      end
    end
    if (ctl_i.load_out) begin
      rgb_q <= rgb_d;
    end
  end

  assign rgb_o = rgb_q;

endmodule

// ----- rtl/core/vertex_diffuse_lighting_unit.sv -----
// vertex diffuse lighting unit: lambert lighting of one vertex normal per word
// sequence per word: the single dot/mac unit visits the n lights in use (0..7)
//   one light a cycle, then flush, clamp and hand-off; a new word is accepted
//   only once the previous result has been taken
// reset: asynchronous active low; all light and ambient registers clear to zero
// depends on vdl_pkg, vdl_seq, vdl_dot_mac
module vertex_diffuse_lighting_unit import vdl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // normal_x, normal_y, normal_z, zero pad
  // output stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // red, green, blue
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [LightW-1:0]   cfg_data_i
);

  // light registers, each read only through the light index mux
  logic [LightW-1:0]    light_q [NumLights];
  logic [AmbW-1:0]      amb_q;
  logic [LightIdxW-1:0] count;
  logic [LightIdxW-1:0] light_idx;
  logic [LightW-1:0]    light_sel;
  ctl_t                 ctl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLights; i++) begin
        light_q[i] <= '0;
      end
      amb_q <= '0;
    end else if (cfg_we_i) begin
      // index seven is the ambient/count register, the rest are lights
      if (cfg_idx_i == RegAmbient) begin
        amb_q <= cfg_data_i[AmbW-1:0];
      end else begin
        light_q[cfg_idx_i] <= cfg_data_i;
      end
    end
  end

  // a 3-bit count never exceeds the seven light registers
  assign count = amb_q[CountLsb +: LightIdxW];

  // index stays below the count, so the unused code seven is never issued
  always_comb begin
    if (light_idx == RegAmbient) begin
      light_sel = '0;
    end else begin
      light_sel = light_q[light_idx];
    end
  end

  vdl_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid),
    .in_ready_o  (s_tready),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .count_i     (count),
    .light_idx_o (light_idx),
    .ctl_o       (ctl)
  );

  // shared unit: dot in the first stage, colour times dot into the accumulators
  // in the second, clamp to a byte when the sequencer loads the output
  vdl_dot_mac u_dot_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .nx_i      (s_tdata[CompW-1:0]),
    .ny_i      (s_tdata[2*CompW-1:CompW]),
    .nz_i      (s_tdata[3*CompW-1:2*CompW]),
    .light_i   (light_sel),
    .ambient_i (amb_q),
    .rgb_o     (m_tdata)
  );

endmodule
